[rtl/pgp_hdr_pkg.sv]
package pgp_hdr_pkg;

   localparam logic [7:0] NEW_FORMAT_MASK = 8'h40;
   localparam logic [7:0] TYPE_MASK       = 8'h3F;
   localparam logic [7:0] LEN_TWO_OCTET   = 8'd192;
   localparam logic [7:0] LEN_PARTIAL     = 8'd224;
   localparam logic [7:0] LEN_FIVE_OCTET  = 8'd255;
   localparam logic [7:0] PARTIAL_MASK    = 8'h1F;
   localparam logic [1:0] OLD_LEN_INDET   = 2'd3;
   localparam logic [2:0] NEW_MULTI_BYTES = 3'd4;

   typedef enum logic [2:0] {
      PH_TAG    = 3'd0,
      PH_NEWLEN = 3'd1,
      PH_SECOND = 3'd2,
      PH_MULTI  = 3'd3
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  bytes_left;
      logic [31:0] length_accum;
      logic [5:0]  held_type;
      logic        held_new_format;
   } parse_state_type;

   typedef struct packed {
      logic [5:0]  pkt_tag;
      logic [31:0] pkt_len;
      logic        new_format;
      logic        partial_length;
   } rsp_type;

endpackage

[rtl/pgp_packet_header_parser.sv]
// a result is registered and appears in the cycle after the byte that completes its header is taken
// throughput: one header byte per cycle, limited only by the result register
// the next byte is taken while a result waits, as long as rsp_ready frees it
// reset (synchronous, active high) returns the parser to expecting a tag byte
// and drops any pending result
module pgp_packet_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_header_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_pkt_tag,
   output logic [31:0] rsp_pkt_len,
   output logic        rsp_new_format,
   output logic        rsp_partial_length
);
   import pgp_hdr_pkg::*;

   parse_state_type state_ff, state_in, step_next;
   rsp_type         step_result, rsp_data;
   logic            step_emit;
   logic            accept;

   assign accept = req_valid && req_ready;

   pgp_hdr_step u_step (
      .cur         (state_ff),
      .header_byte (req_header_byte),
      .nxt         (step_next),
      .emit        (step_emit),
      .result      (step_result)
   );

   pgp_hdr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && step_emit),
      .load_data  (step_result),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .can_accept (req_ready)
   );

   assign state_in = accept ? step_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= PH_TAG;
         state_ff.bytes_left      <= 3'd0;
         state_ff.length_accum    <= 32'd0;
         state_ff.held_type       <= 6'd0;
         state_ff.held_new_format <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_pkt_tag        = rsp_data.pkt_tag;
   assign rsp_pkt_len        = rsp_data.pkt_len;
   assign rsp_new_format     = rsp_data.new_format;
   assign rsp_partial_length = rsp_data.partial_length;

   a_multi_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_MULTI) |-> (state_ff.bytes_left != 3'd0))
      else $error("length byte phase with no bytes left");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_new_partial_pow2 : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_new_format && rsp_partial_length) |-> $onehot(rsp_pkt_len))
      else $error("new format partial length not a power of two");

   a_old_partial_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_new_format) |->
      ((rsp_pkt_tag[5:4] == 2'd0) &&
       (rsp_partial_length == (rsp_pkt_len == 32'd0))))
      else $error("old format result inconsistent");

endmodule

[rtl/pgp_hdr_step.sv]
module pgp_hdr_step (
   input  pgp_hdr_pkg::parse_state_type cur,
   input  logic [7:0]                   header_byte,
   output pgp_hdr_pkg::parse_state_type nxt,
   output logic                         emit,
   output pgp_hdr_pkg::rsp_type         result
);
   import pgp_hdr_pkg::*;

   logic [7:0] c;
   logic [2:0] bl_dec;
   logic [31:0] accum_shift;
   phase_type  nxt_phase;

   assign c           = header_byte;
   assign bl_dec      = cur.bytes_left - 3'd1;
   assign accum_shift = {cur.length_accum[23:0], c};

   // next phase
   always_comb begin
      nxt_phase = PH_TAG;
      case (cur.phase)
         PH_NEWLEN: begin
            if (c >= LEN_TWO_OCTET && c < LEN_PARTIAL) begin
               nxt_phase = PH_SECOND;
            end else if (c == LEN_FIVE_OCTET) begin
               nxt_phase = PH_MULTI;
            end else begin
               nxt_phase = PH_TAG;
            end
         end
         PH_SECOND: nxt_phase = PH_TAG;
         PH_MULTI:  nxt_phase = (bl_dec != 3'd0) ? PH_MULTI : PH_TAG;
         default: begin
            if ((c & NEW_FORMAT_MASK) != 8'd0) begin
               nxt_phase = PH_NEWLEN;
            end else if (c[1:0] == OLD_LEN_INDET) begin
               nxt_phase = PH_TAG;
            end else begin
               nxt_phase = PH_MULTI;
            end
         end
      endcase
   end

   // data state and result
   always_comb begin
      nxt.phase           = nxt_phase;
      nxt.bytes_left      = cur.bytes_left;
      nxt.length_accum    = cur.length_accum;
      nxt.held_type       = cur.held_type;
      nxt.held_new_format = cur.held_new_format;
      emit                = 1'b0;
      result.pkt_tag        = cur.held_type;
      result.pkt_len        = 32'd0;
      result.new_format     = cur.held_new_format;
      result.partial_length = 1'b0;
      case (cur.phase)
         PH_NEWLEN: begin
            if (c < LEN_TWO_OCTET) begin
               emit           = 1'b1;
               nxt.bytes_left = 3'd0;
               result.pkt_len = {24'd0, c};
            end else if (c < LEN_PARTIAL) begin
               nxt.length_accum = {19'd0, c[4:0], 8'd0} + {24'd0, LEN_TWO_OCTET};
            end else if (c == LEN_FIVE_OCTET) begin
               nxt.length_accum = 32'd0;
               nxt.bytes_left   = NEW_MULTI_BYTES;
            end else begin
               emit                  = 1'b1;
               nxt.bytes_left        = 3'd0;
               result.pkt_len        = 32'd1 << c[4:0];
               result.partial_length = 1'b1;
            end
         end
         PH_SECOND: begin
            emit           = 1'b1;
            nxt.bytes_left = 3'd0;
            result.pkt_len = cur.length_accum + {24'd0, c};
         end
         PH_MULTI: begin
            nxt.length_accum = accum_shift;
            nxt.bytes_left   = bl_dec;
            result.pkt_len   = accum_shift;
            if (bl_dec == 3'd0) begin
               emit = 1'b1;
               // old format treats a zero length as partial
               result.partial_length = !cur.held_new_format && (accum_shift == 32'd0);
            end
         end
         default: begin
            nxt.length_accum = 32'd0;
            if ((c & NEW_FORMAT_MASK) != 8'd0) begin
               nxt.held_new_format = 1'b1;
               nxt.held_type       = c[5:0];
               nxt.bytes_left      = 3'd0;
            end else begin
               nxt.held_new_format = 1'b0;
               nxt.held_type       = {2'd0, c[5:2]};
               result.pkt_tag      = {2'd0, c[5:2]};
               result.new_format   = 1'b0;
               if (c[1:0] == OLD_LEN_INDET) begin
                  emit                  = 1'b1;
                  nxt.bytes_left        = 3'd0;
                  result.partial_length = 1'b1;
               end else begin
                  nxt.bytes_left = 3'd1 << c[1:0];
               end
            end
         end
      endcase
   end

endmodule

[rtl/pgp_hdr_out.sv]
module pgp_hdr_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  pgp_hdr_pkg::rsp_type load_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output pgp_hdr_pkg::rsp_type rsp_data,
   output logic                 can_accept
);
   import pgp_hdr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // a new byte may enter when no result is held or the held result leaves this cycle
   assign can_accept = !valid_ff || rsp_ready;
   assign valid_in   = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[dv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pgp_hdr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_header_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_pkt_tag;
   logic [31:0] rsp_pkt_len;
   logic        rsp_new_format;
   logic        rsp_partial_length;

   pgp_packet_header_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_header_byte    (req_header_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pkt_tag        (rsp_pkt_tag),
      .rsp_pkt_len        (rsp_pkt_len),
      .rsp_new_format     (rsp_new_format),
      .rsp_partial_length (rsp_partial_length)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // pending header bytes and headers still owed by the parser
   logic [7:0] header_bytes_q[$];
   rsp_type    expected_headers[$];

   int idle_pct  = 0;
   int stall_pct = 0;
   bit hold_arm  = 1'b0;
   bit rsp_hold  = 1'b0;

   int errors          = 0;
   int bytes_queued    = 0;
   int bytes_sent      = 0;
   int headers_checked = 0;
   int new_seen        = 0;
   int old_seen        = 0;
   int partial_seen    = 0;

   // parser state as the testbench sees it
   phase_type   exp_phase    = PH_TAG;
   logic [2:0]  exp_left     = 3'd0;
   logic [31:0] exp_accum    = 32'd0;
   logic [5:0]  exp_type     = 6'd0;
   logic        exp_new_fmt  = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < 20)
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic decode_header_byte(input logic [7:0] c);
      logic        done;
      logic [31:0] len;
      logic        part;
      rsp_type     hdr;
      done = 1'b0;
      len  = 32'd0;
      part = 1'b0;
      case (exp_phase)
         PH_NEWLEN: begin
            if (c < LEN_TWO_OCTET) begin
               done = 1'b1;
               len  = {24'd0, c};
            end else if (c < LEN_PARTIAL) begin
               exp_accum = {16'd0, c - LEN_TWO_OCTET, 8'd0} + 32'd192;
               exp_phase = PH_SECOND;
            end else if (c == LEN_FIVE_OCTET) begin
               exp_accum = 32'd0;
               exp_left  = NEW_MULTI_BYTES;
               exp_phase = PH_MULTI;
            end else begin
               done = 1'b1;
               len  = 32'd1 << (c & PARTIAL_MASK);
               part = 1'b1;
            end
         end
         PH_SECOND: begin
            done = 1'b1;
            len  = exp_accum + {24'd0, c};
         end
         PH_MULTI: begin
            exp_accum = {exp_accum[23:0], c};
            exp_left  = exp_left - 3'd1;
            if (exp_left == 3'd0) begin
               done = 1'b1;
               len  = exp_accum;
               // old format treats a zero length as indeterminate
               part = !exp_new_fmt && (exp_accum == 32'd0);
            end
         end
         default: begin
            exp_accum = 32'd0;
            if ((c & NEW_FORMAT_MASK) != 8'd0) begin
               exp_new_fmt = 1'b1;
               exp_type    = c[5:0];
               exp_left    = 3'd0;
               exp_phase   = PH_NEWLEN;
            end else begin
               exp_new_fmt = 1'b0;
               exp_type    = {2'b00, c[5:2]};
               if (c[1:0] == OLD_LEN_INDET) begin
                  done = 1'b1;
                  part = 1'b1;
               end else begin
                  exp_left  = 3'd1 << c[1:0];
                  exp_phase = PH_MULTI;
               end
            end
         end
      endcase
      if (done) begin
         hdr.pkt_tag        = exp_type;
         hdr.pkt_len        = len;
         hdr.new_format     = exp_new_fmt;
         hdr.partial_length = part;
         expected_headers   = {expected_headers, hdr};
         exp_phase = PH_TAG;
         exp_left  = 3'd0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic       nv;
      logic [7:0] nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         nb = req_header_byte;
         if (req_valid && req_ready) begin
            decode_header_byte(req_header_byte);
            bytes_sent++;
            nv = 1'b0;
         end
         if (!nv && header_bytes_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
            nv = 1'b1;
            nb = header_bytes_q.pop_front();
         end
         req_valid       <= nv;
         req_header_byte <= nb;
      end
   end

   // receiver side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // long receiver hold-off so the parser backs up into its input
   initial begin
      wait (hold_arm);
      @(negedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(negedge clock);
      rsp_hold = 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_headers.size() == 0) begin
            report_mismatch("unexpected result transfer", rsp_pkt_len, 32'd0);
         end else begin
            want = expected_headers.pop_front();
            if (rsp_pkt_tag != want.pkt_tag)
               report_mismatch("pkt_tag", 32'(rsp_pkt_tag), 32'(want.pkt_tag));
            if (rsp_pkt_len != want.pkt_len)
               report_mismatch("pkt_len", rsp_pkt_len, want.pkt_len);
            if (rsp_new_format != want.new_format)
               report_mismatch("new_format", 32'(rsp_new_format), 32'(want.new_format));
            if (rsp_partial_length != want.partial_length)
               report_mismatch("partial_length", 32'(rsp_partial_length),
                               32'(want.partial_length));
            headers_checked++;
            if (want.new_format) new_seen++;
            else old_seen++;
            if (want.partial_length) partial_seen++;
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      header_bytes_q = {header_bytes_q, b};
      bytes_queued++;
   endtask

   // one well-formed header with random content
   task automatic queue_random_header();
      logic [7:0] tag;
      int         form;
      int         n;
      bit         zero_len;
      tag  = 8'($urandom_range(255, 0));
      form = $urandom_range(3, 0);
      zero_len = ($urandom_range(7, 0) == 0);
      if ($urandom_range(1, 0)) begin
         tag[6] = 1'b1;
         queue_byte(tag);
         case (form)
            0: queue_byte(8'($urandom_range(191, 0)));
            1: begin
               queue_byte(8'($urandom_range(223, 192)));
               queue_byte(8'($urandom_range(255, 0)));
            end
            2: begin
               queue_byte(LEN_FIVE_OCTET);
               repeat (4) queue_byte(zero_len ? 8'd0 : 8'($urandom_range(255, 0)));
            end
            default: queue_byte(8'($urandom_range(254, 224)));
         endcase
      end else begin
         tag[6]   = 1'b0;
         tag[1:0] = form[1:0];
         queue_byte(tag);
         if (tag[1:0] != OLD_LEN_INDET) begin
            n = 1 << tag[1:0];
            repeat (n) queue_byte(zero_len ? 8'd0 : 8'($urandom_range(255, 0)));
         end
      end
   endtask

   task automatic wait_drained();
      while (header_bytes_q.size() != 0 || req_valid || expected_headers.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int start;
      int phase_idle[4];
      int phase_stall[4];
      phase_idle  = '{0, 84, 0, 12};
      phase_stall = '{0, 0, 84, 12};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: length forms at their limits, bit 7 clear, zero old length
      queue_byte(8'hC0); queue_byte(8'd0);
      queue_byte(8'hFF); queue_byte(8'd191);
      queue_byte(8'hC5); queue_byte(8'd223); queue_byte(8'd255);
      queue_byte(8'h7F); queue_byte(8'd224);
      queue_byte(8'hC1); queue_byte(8'd254);
      queue_byte(8'hC2); queue_byte(8'hFF);
      repeat (4) queue_byte(8'hFF);
      queue_byte(8'h80); queue_byte(8'h00);
      queue_byte(8'hBD); queue_byte(8'h12); queue_byte(8'h34);
      queue_byte(8'hBF);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         start = bytes_queued;
         while (bytes_queued - start < 330) begin
            if ($urandom_range(9, 0) == 0) queue_byte(8'($urandom_range(255, 0)));
            else queue_random_header();
         end
         wait_drained();

         if (p == 0) begin
            // receiver held off while headers keep coming
            hold_arm = 1'b1;
            repeat (40) queue_random_header();
            wait_drained();
         end
      end

      repeat (8) @(posedge clock);
      $display("sent %0d header bytes, checked %0d headers: %0d new format, %0d old, %0d partial",
               bytes_sent, headers_checked, new_seen, old_seen, partial_seen);
      $display("idling phases: none, sender 84%%, receiver 84%%, both 12%%, plus a long hold-off");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d headers outstanding", expected_headers.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
rtl/pgp_hdr_pkg.sv
rtl/pgp_hdr_step.sv
rtl/pgp_hdr_out.sv
rtl/pgp_packet_header_parser.sv
dv/tb_top.sv
